[rtl/acg_pkg.sv]
// shared types, constants and arithmetic steps of the anisotropic covariance grid core
`default_nettype none

package acg_pkg;

  localparam int AXIS_SIZE_DEFAULT = 256;

  // model codes
  localparam logic [1:0] MODEL_SPHERICAL   = 2'd0;
  localparam logic [1:0] MODEL_EXPONENTIAL = 2'd1;
  localparam logic [1:0] MODEL_GAUSSIAN    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODEL_SELECT   = 3'd0;
  localparam logic [2:0] REG_INVERSE_RANGE  = 3'd1;
  localparam logic [2:0] REG_ROTATION_ROW_X = 3'd2;
  localparam logic [2:0] REG_ROTATION_ROW_Y = 3'd3;
  localparam logic [2:0] REG_ROTATION_ROW_Z = 3'd4;
  localparam logic [2:0] REG_CENTER_OFFSETS = 3'd5;

  localparam logic [23:0] INVERSE_RANGE_RESET = 24'd65536;
  localparam logic [17:0] DIST_MAX            = 18'd262143;
  localparam logic [30:0] LOG2E_Q30           = 31'd1549082005;
  localparam logic [29:0] LN2_Q30             = 30'd744261118;
  localparam logic [30:0] ONE_Q30             = 31'd1073741824;

  typedef struct packed {
    logic [43:0] rad;
    logic [25:0] rem;
    logic [21:0] root;
  } sqrt_t;

  // one digit of the square root: two radicand bits in, one root bit out
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t       o;
    logic [25:0] rem2;
    logic [25:0] trial;
    rem2  = {s.rem[23:0], s.rad[43:42]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[41:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[20:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[20:0], 1'b0};
    end
    return o;
  endfunction

  // index modulo a constant axis size by shifted compare and subtract
  function automatic logic [7:0] axis_mod(input logic [7:0] v, input int n);
    logic [7:0] r;
    r = v;
    for (int s = 7; s >= 0; s--) begin
      if (int'(r) >= (n << s)) begin
        r = r - 8'(n << s);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/anisotropic_covariance_grid_core.sv]
// top level of the anisotropic covariance grid core
`default_nettype none

// Takes one grid cell (index_x, index_y, index_z) per item, centers it, rotates it with
// the anisotropic 3x3 matrix, takes the Euclidean length (scaled_distance, Q10.8,
// saturating) and gives the correlation (covariance, Q1.15) of the selected model:
// spherical, exponential or gaussian, and 0 for the unused model code. One item enters
// every clock unless a full pipeline stalls at the output. The square root has 11
// stages (two root bits a stage), the 8-term exponential series three stages a term.
// Every stage has its own valid bit and moves on when the next is free, so bubbles close
// up and input is taken while a result waits if a stage is empty. The user must write
// configuration through cfg_we/cfg_addr/cfg_wdata only while no item is in flight; the core does not enforce it.
module anisotropic_covariance_grid_core
  import acg_pkg::*;
#(
  parameter int AXIS_SIZE = AXIS_SIZE_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // index_x, index_y, index_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // covariance, scaled_distance, zero pad
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [47:0] cfg_wdata
);

  localparam int ST_IDX   = 0;
  localparam int ST_CEN   = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_ROT   = 3;
  localparam int ST_SQ    = 4;
  localparam int ST_SUM   = 5;
  localparam int ST_SQRT0 = 6;
  localparam int SQRT_ST  = 11;
  localparam int ST_HPROD = ST_SQRT0 + SQRT_ST;
  localparam int ST_H     = ST_HPROD + 1;
  localparam int ST_E1    = ST_H + 1;
  localparam int ST_E2    = ST_E1 + 1;
  localparam int ST_E3    = ST_E2 + 1;
  localparam int ST_E4    = ST_E3 + 1;
  localparam int ST_U     = ST_E4 + 1;
  localparam int ST_HORN  = ST_U + 1;
  localparam int TERMS    = 8;
  localparam int ST_OUT   = ST_HORN + 3 * TERMS;
  localparam int NS       = ST_OUT + 1;

  // configuration registers
  logic [1:0]  model_select;
  logic [23:0] inverse_range;
  logic [47:0] rot [3];
  logic [47:0] center_offsets;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_select   <= MODEL_SPHERICAL;
      inverse_range  <= INVERSE_RANGE_RESET;
      rot[0]         <= '0;
      rot[1]         <= '0;
      rot[2]         <= '0;
      center_offsets <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODEL_SELECT:   model_select   <= cfg_wdata[1:0];
        REG_INVERSE_RANGE:  inverse_range  <= cfg_wdata[23:0];
        REG_ROTATION_ROW_X: rot[0]         <= cfg_wdata;
        REG_ROTATION_ROW_Y: rot[1]         <= cfg_wdata;
        REG_ROTATION_ROW_Z: rot[2]         <= cfg_wdata;
        REG_CENTER_OFFSETS: center_offsets <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage control: a stage loads when it is empty or the next one loads
  logic [NS-1:0] valid;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !valid[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // datapath registers
  logic [7:0]         idx_r  [3];
  logic signed [17:0] c_r    [3];
  logic signed [33:0] prod_r [3][3];
  logic [20:0]        rq_r   [3];
  logic [20:0]        rq     [3];
  logic [41:0]        sq_r   [3];
  logic [43:0]        ssum_r;
  sqrt_t              sq_st  [SQRT_ST];
  logic [41:0]        hprod_r;
  logic [33:0]        h_r;
  logic [16:0]        sph_hc_r;
  logic [32:0]        sph_hc2_r;
  logic [18:0]        exp_hc_r;
  logic [36:0]        exp_hc2_r;
  logic [48:0]        sph_hc3_r;
  logic [16:0]        sph_hcd_r;
  logic [21:0]        x_r;
  logic [52:0]        y_r;
  logic [29:0]        gs_r;

  // values that ride along the later stages
  logic [17:0] d_c    [NS];
  logic [15:0] covs_c [NS];
  logic [6:0]  n_c    [NS];
  logic [29:0] u_c    [NS];

  // combinational pieces
  logic signed [35:0] rsum [3];
  logic [35:0]        rmag [3];
  logic [35:0]        rrnd [3];
  logic [17:0]        d_sat;
  logic [16:0]        sph_hc;
  logic [18:0]        exp_hc;
  logic [21:0]        x_exp;
  logic [38:0]        x_gau_full;
  logic [22:0]        x_raw;
  logic [51:0]        t_sph;
  logic [51:0]        t_rnd;
  logic [29:0]        u_calc;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = prod_r[r][0] + prod_r[r][1] + prod_r[r][2];
      rmag[r] = rsum[r][35] ? 36'(-rsum[r]) : 36'(rsum[r]);
      rrnd[r] = rmag[r] + 36'd2048;
      rq[r]   = rrnd[r][32:12];
    end
    d_sat  = (sq_st[SQRT_ST-1].root > 22'(DIST_MAX)) ? DIST_MAX
                                                     : sq_st[SQRT_ST-1].root[17:0];
    sph_hc = (h_r > 34'd65536) ? 17'd65536 : h_r[16:0];
    exp_hc = (h_r > 34'd262144) ? 19'd262144 : h_r[18:0];
    x_exp      = 22'(exp_hc_r) * 22'd3;
    x_gau_full = 39'(exp_hc2_r) * 39'd3;
    x_raw  = (model_select == MODEL_EXPONENTIAL) ? 23'(x_exp) : x_gau_full[38:16];
    t_sph  = 52'(64'd1 << 49) + 52'(sph_hc3_r) - ((52'(sph_hcd_r) * 52'd3) << 32);
    t_rnd  = t_sph + 52'(64'd1 << 33);
    u_calc = 30'((60'(gs_r) * 60'(LN2_Q30)) >> 30);
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        d_c[i]    <= (i == ST_HPROD) ? d_sat : d_c[i-1];
        covs_c[i] <= (i == ST_E3) ? t_rnd[49:34] : covs_c[i-1];
        n_c[i]    <= (i == ST_E4) ? y_r[52:46] : n_c[i-1];
        u_c[i]    <= (i == ST_U) ? u_calc : u_c[i-1];
      end
    end
    if (en[ST_IDX]) begin
      d_c[0]    <= '0;
      covs_c[0] <= '0;
      n_c[0]    <= '0;
      u_c[0]    <= '0;
      for (int a = 0; a < 3; a++) begin
        idx_r[a] <= axis_mod(s_tdata[8*a +: 8], AXIS_SIZE);
      end
    end
    if (en[ST_CEN]) begin
      for (int a = 0; a < 3; a++) begin
        c_r[a] <= $signed({4'b0, idx_r[a], 6'b0})
                - $signed({{2{center_offsets[16*a+15]}}, center_offsets[16*a +: 16]});
      end
    end
    if (en[ST_MUL]) begin
      for (int r = 0; r < 3; r++) begin
        for (int a = 0; a < 3; a++) begin
          prod_r[r][a] <= $signed(rot[r][16*a +: 16]) * c_r[a];
        end
      end
    end
    if (en[ST_ROT]) begin
      for (int r = 0; r < 3; r++) begin
        rq_r[r] <= rq[r];
      end
    end
    if (en[ST_SQ]) begin
      for (int r = 0; r < 3; r++) begin
        sq_r[r] <= 42'(rq_r[r]) * 42'(rq_r[r]);
      end
    end
    if (en[ST_SUM]) begin
      ssum_r <= 44'(sq_r[0]) + 44'(sq_r[1]) + 44'(sq_r[2]);
    end
    if (en[ST_SQRT0]) begin
      sq_st[0] <= sqrt_step(sqrt_step('{rad: ssum_r, rem: '0, root: '0}));
    end
    for (int k = 1; k < SQRT_ST; k++) begin
      if (en[ST_SQRT0+k]) begin
        sq_st[k] <= sqrt_step(sqrt_step(sq_st[k-1]));
      end
    end
    if (en[ST_HPROD]) begin
      hprod_r <= 42'(d_sat) * 42'(inverse_range);
    end
    if (en[ST_H]) begin
      h_r <= 34'((hprod_r + 42'd128) >> 8);
    end
    if (en[ST_E1]) begin
      sph_hc_r  <= sph_hc;
      sph_hc2_r <= 33'(sph_hc) * 33'(sph_hc);
      exp_hc_r  <= exp_hc;
      exp_hc2_r <= 37'(exp_hc) * 37'(exp_hc);
    end
    if (en[ST_E2]) begin
      sph_hc3_r <= 49'(sph_hc2_r) * 49'(sph_hc_r);
      sph_hcd_r <= sph_hc_r;
      x_r       <= (x_raw > 23'd2097152) ? 22'd2097152 : x_raw[21:0];
    end
    if (en[ST_E3]) begin
      y_r <= 53'(x_r) * 53'(LOG2E_Q30);
    end
    if (en[ST_E4]) begin
      gs_r <= y_r[45:16];
    end
  end

  // series for e^-u, Horner form from the highest term down, three stages a term
  logic [59:0] hz_prod [TERMS];
  logic [29:0] hz_q    [TERMS];
  logic [65:0] hz_qm   [TERMS];
  logic [30:0] hz_p    [TERMS];

  for (genvar j = 0; j < TERMS; j++) begin : g_term
    localparam int          K     = TERMS - j;
    localparam logic [34:0] RECIP = 35'((64'd1 << 34) / K);
    localparam int          SA    = ST_HORN + 3 * j;

    logic [30:0] p_in;
    logic [31:0] est;
    logic [31:0] rem;
    logic [31:0] quo;

    if (j == 0) begin : g_first
      assign p_in = ONE_Q30;
    end else begin : g_next
      assign p_in = hz_p[j-1];
    end

    // reciprocal estimate is exact or one low
    always_comb begin
      est = hz_qm[j][65:34];
      rem = 32'(hz_q[j]) - est * 32'(K);
      quo = (rem >= 32'(K)) ? est + 32'd1 : est;
    end

    always_ff @(posedge clk) begin
      if (en[SA]) begin
        hz_prod[j] <= 60'(61'(u_c[SA-1]) * 61'(p_in));
      end
      if (en[SA+1]) begin
        hz_q[j]  <= hz_prod[j][59:30];
        hz_qm[j] <= 66'(hz_prod[j][59:30]) * 66'(RECIP);
      end
      if (en[SA+2]) begin
        hz_p[j] <= ONE_Q30 - quo[30:0];
      end
    end
  end

  // output stage
  logic [15:0] out_cov;
  logic [17:0] out_dist;
  logic [63:0] e_sum;
  logic [63:0] e_shift;
  logic [15:0] cov_exp;
  logic [15:0] cov_sel;

  always_comb begin
    e_sum   = 64'(hz_p[TERMS-1]) + (64'd1 << (7'd14 + n_c[ST_OUT-1]));
    e_shift = e_sum >> (7'd15 + n_c[ST_OUT-1]);
    cov_exp = e_shift[15:0];
    unique case (model_select)
      MODEL_SPHERICAL:   cov_sel = covs_c[ST_OUT-1];
      MODEL_EXPONENTIAL: cov_sel = cov_exp;
      MODEL_GAUSSIAN:    cov_sel = cov_exp;
      default:           cov_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_cov  <= cov_sel;
      out_dist <= d_c[ST_OUT-1];
    end
  end

  assign m_tdata = {6'b0, out_dist, out_cov};

`ifndef SYNTHESIS
  // a taking sink frees every stage, so the input is never held off
  a_ready_when_sink_takes: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input held off while output is taken");

  // correlation never exceeds one
  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_cov <= 16'd32768)
    else $error("covariance above one");

  // root digits leave a remainder no larger than twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    valid[ST_SQRT0+SQRT_ST-1] |->
      sq_st[SQRT_ST-1].rem <= {3'b0, sq_st[SQRT_ST-1].root, 1'b0})
    else $error("square root remainder out of bound");
`endif

endmodule

`default_nettype wire
